// File: rtl/core/swfp_pkg.sv
// ----------------------------------------------------------------------------
// swfp_pkg
// Shared types and constants of the sync-word frame parser.
// ----------------------------------------------------------------------------
package swfp_pkg;

	localparam int unsigned MaxFrameLenDefault = 32;
	localparam int unsigned StoreDepth         = 32;
	localparam int unsigned AddrW              = $clog2(StoreDepth);
	localparam int unsigned LenW               = 6;
	localparam int unsigned ByteW              = 8;

	localparam logic [ByteW-1:0] SyncU    = 8'h55;
	localparam logic [ByteW-1:0] SyncN    = 8'h4E;
	localparam logic [ByteW-1:0] SyncE    = 8'h45;
	localparam logic [ByteW-1:0] SyncR    = 8'h52;
	localparam logic [ByteW-1:0] TokenSep = 8'h3A;
	localparam logic [ByteW-1:0] XorSeed  = SyncU ^ SyncN ^ SyncE ^ SyncR ^ TokenSep;

	typedef enum logic [3:0] {
		ST_HUNT,
		ST_SYNC_N,
		ST_SYNC_E,
		ST_SYNC_R,
		ST_LENGTH,
		ST_TOKEN,
		ST_PAYLOAD,
		ST_CHECK,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic ld_len;
		logic init_frame;
		logic wr_payload;
		logic start_drain;
		logic rd_step;
	} cmd_t;

	typedef struct packed {
		logic is_u;
		logic is_n;
		logic is_e;
		logic is_r;
		logic is_token;
		logic len_ok;
		logic last_payload;
		logic xor_match;
		logic out_free;
		logic drain_last;
	} status_t;

endpackage

// File: rtl/core/swfp_ctrl.sv
// ----------------------------------------------------------------------------
// swfp_ctrl
// Frame parse state machine: sync hunt, length, token, payload, checksum and
// payload drain sequencing.
// ----------------------------------------------------------------------------
module swfp_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  swfp_pkg::status_t sts,
	output swfp_pkg::cmd_t   cmd
);
	import swfp_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   acc;
	state_t restart;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HUNT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		in_ready = (state_q != ST_DRAIN);
		acc      = in_valid && in_ready;
		restart  = sts.is_u ? ST_SYNC_N : ST_HUNT;
		cmd      = '0;
		state_d  = state_q;
		unique case (state_q)
			ST_HUNT: begin
				if (acc) state_d = restart;
			end
			ST_SYNC_N: begin
				if (acc) state_d = sts.is_n ? ST_SYNC_E : restart;
			end
			ST_SYNC_E: begin
				if (acc) state_d = sts.is_e ? ST_SYNC_R : restart;
			end
			ST_SYNC_R: begin
				if (acc) state_d = sts.is_r ? ST_LENGTH : restart;
			end
			ST_LENGTH: begin
				if (acc) begin
					cmd.ld_len = sts.len_ok;
					state_d    = sts.len_ok ? ST_TOKEN : ST_HUNT;
				end
			end
			ST_TOKEN: begin
				if (acc) begin
					cmd.init_frame = sts.is_token;
					state_d        = sts.is_token ? ST_PAYLOAD : restart;
				end
			end
			ST_PAYLOAD: begin
				if (acc) begin
					cmd.wr_payload = 1'b1;
					if (sts.last_payload) state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (acc) begin
					cmd.start_drain = sts.xor_match;
					state_d         = sts.xor_match ? ST_DRAIN : ST_HUNT;
				end
			end
			ST_DRAIN: begin
				cmd.rd_step = sts.out_free;
				if (sts.out_free && sts.drain_last) state_d = ST_HUNT;
			end
			default: state_d = ST_HUNT;
		endcase
	end

endmodule

// File: rtl/core/swfp_dp.sv
// ----------------------------------------------------------------------------
// swfp_dp
// Parser datapath: byte compares, length and checksum registers, payload
// store and the output register.
// ----------------------------------------------------------------------------
module swfp_dp #(
	parameter int unsigned MAX_FRAME_LEN = swfp_pkg::MaxFrameLenDefault
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [swfp_pkg::ByteW-1:0] rx_byte,
	input  swfp_pkg::cmd_t             cmd,
	output swfp_pkg::status_t          sts,
	input  logic                       out_ready,
	output logic                       out_valid,
	output logic [swfp_pkg::ByteW-1:0] data_byte,
	output logic [swfp_pkg::AddrW-1:0] byte_index,
	output logic [swfp_pkg::LenW-1:0]  frame_len,
	output logic                       last_byte
);
	import swfp_pkg::*;

	localparam int unsigned LenLimit =
		(MAX_FRAME_LEN < StoreDepth) ? MAX_FRAME_LEN : StoreDepth;

	logic [ByteW-1:0] mem [StoreDepth];
	logic [LenW-1:0]  len_q;
	logic [ByteW-1:0] xor_q;
	logic [AddrW-1:0] wr_pos_q;
	logic [AddrW-1:0] rd_cnt_q;
	logic             out_valid_q;
	logic [ByteW-1:0] rd_data_q;
	logic [AddrW-1:0] idx_q;
	logic [LenW-1:0]  olen_q;
	logic             last_q;
	logic             rd_last;

	assign rd_last = ({1'b0, rd_cnt_q} + LenW'(2)) == len_q;

	always_comb begin
		sts.is_u         = (rx_byte == SyncU);
		sts.is_n         = (rx_byte == SyncN);
		sts.is_e         = (rx_byte == SyncE);
		sts.is_r         = (rx_byte == SyncR);
		sts.is_token     = (rx_byte == TokenSep);
		sts.len_ok       = (rx_byte >= ByteW'(2)) && (rx_byte <= ByteW'(LenLimit));
		sts.last_payload = ({1'b0, wr_pos_q} + LenW'(2)) == len_q;
		sts.xor_match    = (rx_byte == xor_q);
		sts.out_free     = !out_valid_q || out_ready;
		sts.drain_last   = rd_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= '0;
			xor_q    <= '0;
			wr_pos_q <= '0;
			rd_cnt_q <= '0;
		end else begin
			if (cmd.ld_len) len_q <= rx_byte[LenW-1:0];
			if (cmd.init_frame) begin
				xor_q    <= XorSeed ^ {{(ByteW-LenW){1'b0}}, len_q};
				wr_pos_q <= '0;
			end else if (cmd.wr_payload) begin
				xor_q    <= xor_q ^ rx_byte;
				wr_pos_q <= wr_pos_q + AddrW'(1);
			end
			if (cmd.start_drain) begin
				rd_cnt_q <= '0;
			end else if (cmd.rd_step) begin
				rd_cnt_q <= rd_cnt_q + AddrW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_payload) mem[wr_pos_q] <= rx_byte;
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_step) begin
			rd_data_q <= mem[rd_cnt_q];
			idx_q     <= rd_cnt_q;
			olen_q    <= len_q;
			last_q    <= rd_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.rd_step) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign data_byte  = rd_data_q;
	assign byte_index = idx_q;
	assign frame_len  = olen_q;
	assign last_byte  = last_q;

endmodule

// File: rtl/core/sync_word_frame_parser_xor_check.sv
// ----------------------------------------------------------------------------
// sync_word_frame_parser_xor_check
// Byte-stream frame parser with sync header and XOR checksum.
// ----------------------------------------------------------------------------
// Bytes arrive on s_tdata, one per cycle while the parser hunts for the
// four-byte sync header, reads the length byte N (2 to the lesser of
// MAX_FRAME_LEN and 32), the ':' token, the N-1 payload bytes and the XOR
// checksum. On a checksum match the payload is replayed from the 32-entry
// payload store on the master side, one byte per cycle while the output
// register is free, with tlast on the final byte. s_tready is low from the
// checksum until the last of those N-1 bytes is issued, a drain paced by the
// single read port of the store and prolonged by output stalls. A mismatching
// checksum drops the frame with no output; a mismatching header or token
// byte is rechecked as a first sync byte.
// ----------------------------------------------------------------------------
module sync_word_frame_parser_xor_check #(
	parameter int unsigned MAX_FRAME_LEN = swfp_pkg::MaxFrameLenDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [7:0] data_byte, [12:8] byte_index, [18:13] frame_len
	output logic        m_tlast
);
	import swfp_pkg::*;

	cmd_t             cmd;
	status_t          sts;
	logic [ByteW-1:0] data_byte;
	logic [AddrW-1:0] byte_index;
	logic [LenW-1:0]  frame_len;

	swfp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	swfp_dp #(
		.MAX_FRAME_LEN (MAX_FRAME_LEN)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx_byte    (s_tdata),
		.cmd        (cmd),
		.sts        (sts),
		.out_ready  (m_tready),
		.out_valid  (m_tvalid),
		.data_byte  (data_byte),
		.byte_index (byte_index),
		.frame_len  (frame_len),
		.last_byte  (m_tlast)
	);

	assign m_tdata = {5'b0, frame_len, byte_index, data_byte};

	a_last_matches_index: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (({1'b0, byte_index} + 6'd2) == frame_len)))
		else $error("tlast disagrees with byte index and frame length");

	a_index_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (({1'b0, byte_index} + 6'd2) <= frame_len))
		else $error("byte index beyond frame payload");

	a_no_input_on_drain: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_step |-> !s_tready)
		else $error("input accepted while payload drains");

endmodule

// File: test/swfp_frame_checker.sv
// ----------------------------------------------------------------------------
// swfp_frame_checker
// Watches both stream channels of the frame parser, tracks the parse state
// from every accepted request byte, queues the payload bytes a matching
// checksum releases and compares each output beat against the oldest one.
// ----------------------------------------------------------------------------
module swfp_frame_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,   // [7:0] data_byte, [12:8] byte_index, [18:13] frame_len
	input  logic        m_tlast,
	output int          fail_count,
	output int          backlog
);
	timeunit 1ns;
	timeprecision 1ps;
	import swfp_pkg::*;

	localparam int unsigned LenLimit =
		(MaxFrameLenDefault < StoreDepth) ? MaxFrameLenDefault : StoreDepth;

	typedef struct {
		logic [7:0] data_byte;
		logic [4:0] byte_index;
		logic [5:0] frame_len;
		logic       last_byte;
	} payload_beat_t;

	payload_beat_t released_beats[$];
	state_t        phase;
	logic [5:0]    len_val;
	logic [5:0]    left;
	logic [7:0]    xor_acc;
	logic [7:0]    store [StoreDepth];
	int            mismatches = 0;

	assign fail_count = mismatches;

	function automatic state_t resync(input logic [7:0] b);
		return (b == SyncU) ? ST_SYNC_N : ST_HUNT;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0h, actual %0h", name, want, got);
			mismatches++;
		end
	endfunction

	task automatic parse_rx_byte(input logic [7:0] b);
		payload_beat_t beat;
		int n;
		case (phase)
			ST_HUNT:   phase = resync(b);
			ST_SYNC_N: phase = (b == SyncN) ? ST_SYNC_E : resync(b);
			ST_SYNC_E: phase = (b == SyncE) ? ST_SYNC_R : resync(b);
			ST_SYNC_R: phase = (b == SyncR) ? ST_LENGTH : resync(b);
			ST_LENGTH: begin
				if (b < 2 || b > LenLimit) begin
					phase = ST_HUNT;
				end else begin
					len_val = b[5:0];
					phase = ST_TOKEN;
				end
			end
			ST_TOKEN: begin
				if (b == TokenSep) begin
					xor_acc = XorSeed ^ {2'b00, len_val};
					left = len_val - 6'd1;
					phase = ST_PAYLOAD;
				end else begin
					phase = resync(b);
				end
			end
			ST_PAYLOAD: begin
				store[5'(len_val - 6'd1 - left)] = b;
				xor_acc ^= b;
				left = left - 6'd1;
				if (left == 6'd0) phase = ST_CHECK;
			end
			ST_CHECK: begin
				if (b == xor_acc) begin
					n = int'(len_val) - 1;
					for (int k = 0; k < n; k++) begin
						beat.data_byte  = store[k];
						beat.byte_index = 5'(k);
						beat.frame_len  = len_val;
						beat.last_byte  = (k == n - 1);
						released_beats.push_back(beat);
					end
				end
				phase = ST_HUNT;
			end
			default: phase = ST_HUNT;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		payload_beat_t want;
		if (!arst_n) begin
			phase   = ST_HUNT;
			len_val = '0;
			left    = '0;
			xor_acc = '0;
			released_beats.delete();
			backlog <= 0;
		end else begin
			if (s_tvalid && s_tready) parse_rx_byte(s_tdata);
			if (m_tvalid && m_tready) begin
				if (released_beats.size() == 0) begin
					$error("unexpected payload beat: data_byte %0h", m_tdata[7:0]);
					mismatches++;
				end else begin
					want = released_beats.pop_front();
					check_field("data_byte", 32'(want.data_byte), 32'(m_tdata[7:0]));
					check_field("byte_index", 32'(want.byte_index), 32'(m_tdata[12:8]));
					check_field("frame_len", 32'(want.frame_len), 32'(m_tdata[18:13]));
					check_field("pad", 32'(0), 32'(m_tdata[23:19]));
					check_field("last_byte", 32'(want.last_byte), 32'(m_tlast));
				end
			end
			backlog <= released_beats.size();
		end
	end

endmodule

// File: test/tb_sync_word_frame_parser_xor_check.sv
// ----------------------------------------------------------------------------
// tb_sync_word_frame_parser_xor_check
// Stimulus and verdict for the sync-word frame parser.
// ----------------------------------------------------------------------------
// Feeds directed byte sequences for header restarts, length limits, token
// and checksum mismatches, then mostly well-formed frames with random
// payload mixed with noise and broken frames, under several idle patterns
// and one long output hold-off. The checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_sync_word_frame_parser_xor_check;
	timeunit 1ns;
	timeprecision 1ps;
	import swfp_pkg::*;

	localparam int unsigned LenLimit =
		(MaxFrameLenDefault < StoreDepth) ? MaxFrameLenDefault : StoreDepth;
	localparam int RxHoldCycles = 400;
	localparam int PhaseBytes   = 10;

	typedef enum int {
		FLAW_NONE,
		FLAW_SYNC,
		FLAW_LEN,
		FLAW_TOKEN,
		FLAW_CSUM
	} flaw_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = 8'h00;   // [7:0] rx_byte
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;            // [7:0] data_byte, [12:8] byte_index, [18:13] frame_len
	logic        m_tlast;
	int          fail_count;
	int          backlog;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_seq      = 0;
	int sent          = 0;

	always #10 clk = ~clk;

	sync_word_frame_parser_xor_check dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	swfp_frame_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.fail_count (fail_count),
		.backlog    (backlog)
	);

	function automatic logic [7:0] wrong_byte(input logic [7:0] good);
		logic [7:0] b;
		b = ($urandom_range(3) == 0) ? SyncU : 8'($urandom);
		if (b == good) b = good ^ 8'h01;
		return b;
	endfunction

	// Call at a falling edge; returns at the falling edge after acceptance.
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		sent++;
		@(negedge clk);
	endtask

	task automatic send_header();
		send_byte(SyncU);
		send_byte(SyncN);
		send_byte(SyncE);
		send_byte(SyncR);
	endtask

	task automatic send_frame(input int len, input flaw_t flaw, input int fill);
		logic [7:0] hdr [4];
		logic [7:0] sum;
		logic [7:0] b;
		int cut;
		hdr = '{SyncU, SyncN, SyncE, SyncR};
		cut = $urandom_range(3);
		for (int i = 0; i < 4; i++) begin
			if (flaw == FLAW_SYNC && i == cut) begin
				send_byte(wrong_byte(hdr[i]));
				return;
			end
			send_byte(hdr[i]);
		end
		if (flaw == FLAW_LEN)
			send_byte($urandom_range(1) ? 8'($urandom_range(1))
				: 8'($urandom_range(255, LenLimit + 1)));
		else
			send_byte(8'(len));
		send_byte(flaw == FLAW_TOKEN ? wrong_byte(TokenSep) : TokenSep);
		sum = XorSeed ^ 8'(len);
		for (int i = 0; i < len - 1; i++) begin
			b = (fill < 0) ? 8'($urandom) : 8'(fill);
			sum ^= b;
			send_byte(b);
		end
		send_byte(flaw == FLAW_CSUM ? sum ^ 8'($urandom_range(255, 1)) : sum);
	endtask

	initial begin : receiver
		int seen;
		seen = 0;
		forever begin
			@(negedge clk);
			if (hold_seq != seen) begin
				seen = hold_seq;
				m_tready <= 1'b0;
				repeat (RxHoldCycles - 1) @(negedge clk);
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	initial begin : timeout
		#4_000_000;
		$display("tb_sync_word_frame_parser_xor_check failed");
		$finish;
	end

	initial begin : stimulus
		int send_pct [4];
		int recv_pct [4];
		int target;
		int len;
		flaw_t flaw;
		send_pct = '{0, 63, 0, 36};
		recv_pct = '{0, 0, 63, 36};
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// restart on U in the E slot, then the shortest frame of all ones
		send_byte(SyncU);
		send_byte(SyncN);
		send_frame(2, FLAW_NONE, 8'hFF);
		// lengths below and above the limit
		send_header();
		send_byte(8'd1);
		send_header();
		send_byte(8'(LenLimit + 1));
		// a U as length byte is consumed, not resynced
		send_header();
		send_byte(SyncU);
		send_byte(SyncN);
		send_byte(SyncE);
		send_byte(SyncR);
		send_byte(8'd2);
		send_byte(TokenSep);
		send_byte(8'h00);
		send_byte(XorSeed ^ 8'd2);
		// token replaced by U restarts the header
		send_header();
		send_byte(8'd3);
		send_frame(3, FLAW_NONE, 8'h00);
		send_frame(4, FLAW_CSUM, -1);
		send_frame(LenLimit, FLAW_NONE, -1);

		for (int p = 0; p < 4; p++) begin
			send_idle_pct = send_pct[p];
			recv_idle_pct = recv_pct[p];
			target = sent + PhaseBytes;
			while (sent < target) begin
				if ($urandom_range(99) < 15) begin
					repeat ($urandom_range(3, 1)) send_byte(8'($urandom));
				end else begin
					case ($urandom_range(99)) inside
						[0:84]:  len = $urandom_range(8, 2);
						[85:94]: len = $urandom_range(LenLimit - 1, 9);
						default: len = LenLimit;
					endcase
					flaw = ($urandom_range(99) < 70) ? FLAW_NONE
						: flaw_t'($urandom_range(4, 1));
					send_frame(len, flaw, -1);
				end
			end
			if (p == 1) begin
				// hold the output while the sender keeps pushing frames
				send_idle_pct = 0;
				hold_seq++;
				repeat (4) send_frame(6, FLAW_NONE, -1);
			end
		end

		s_tvalid <= 1'b0;
		recv_idle_pct = 0;
		while (backlog != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (fail_count == 0) begin
			$display("tb_sync_word_frame_parser_xor_check passed");
		end else begin
			$display("tb_sync_word_frame_parser_xor_check failed");
		end
		$finish;
	end

endmodule
